// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hdl/wrst_pkg.sv =====
`default_nettype none

package wrst_pkg;

	localparam int POOL_SLOTS_DEF = 32;
	localparam int RADIUS_DEF     = 2;
	localparam int COORD_W        = 16;
	localparam int SLOT_W         = 5;

	localparam logic ACT_EVICT = 1'b0;
	localparam logic ACT_LOAD  = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_z;
	} req_t;

	typedef struct packed {
		logic                      action;
		logic [SLOT_W-1:0]         slot_index;
		logic signed [COORD_W-1:0] tile_x;
		logic signed [COORD_W-1:0] tile_z;
		logic                      last_action;
	} res_t;

	// result events from the sequencer to the output stage
	typedef struct packed {
		logic new_v;
		logic flush;
		res_t res;
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVICT,
		ST_SEARCH,
		ST_LOAD,
		ST_FLUSH
	} state_t;

	// true when tile coordinate a lies more than r away from center b (mod 2^16)
	function automatic logic win_outside(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
		int r);
		logic signed [COORD_W-1:0] d;
		logic signed [COORD_W-1:0] rr;
		d  = $signed(a - b);
		rr = $signed(COORD_W'(r));
		return (d > rr) || (d < -rr);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/wrst_ram.sv =====
`default_nettype none

module wrst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wrst_seq.sv =====
`default_nettype none

module wrst_seq #(
	parameter int POOL_SLOTS = wrst_pkg::POOL_SLOTS_DEF,
	parameter int RADIUS     = wrst_pkg::RADIUS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire wrst_pkg::req_t                  request,
	output logic                                 busy,
	output logic                                 ram_we,
	output logic [$clog2(POOL_SLOTS)-1:0]        ram_waddr,
	output logic [2*wrst_pkg::COORD_W-1:0]       ram_wdata,
	output logic                                 ram_re,
	output logic [$clog2(POOL_SLOTS)-1:0]        ram_raddr,
	input  wire logic [2*wrst_pkg::COORD_W-1:0]  ram_rdata,
	output wrst_pkg::ev_t                        ev
);

	import wrst_pkg::*;

	localparam int AW   = $clog2(POOL_SLOTS);
	localparam int SW   = $clog2(POOL_SLOTS + 1);
	localparam int SPAN = 2 * RADIUS + 1;
	localparam int OW   = $clog2(SPAN);

	state_t state_q, state_d;

	logic [SW-1:0]         cnt_q;
	logic                  rd_v_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic [POOL_SLOTS-1:0] valid_q;
	logic [COORD_W-1:0]    cx_q, cz_q;
	logic [COORD_W-1:0]    prev_x_q, prev_z_q;
	logic                  has_center_q;
	logic [OW-1:0]         off_x_q, off_z_q;
	logic                  match_q;
	logic                  free_v_q;
	logic [AW-1:0]         free_idx_q;

	logic               move;
	logic               issue;
	logic               pass_end;
	logic               last_tile;
	logic               do_load;
	logic               do_evict;
	logic [COORD_W-1:0] tile_x, tile_z;
	logic [COORD_W-1:0] rd_x, rd_z;

	assign rd_x = ram_rdata[2*COORD_W-1:COORD_W];
	assign rd_z = ram_rdata[COORD_W-1:0];

	assign move = !has_center_q || (request.center_x != prev_x_q)
		|| (request.center_z != prev_z_q);
	assign issue = ((state_q == ST_EVICT) || (state_q == ST_SEARCH)) && (cnt_q != SW'(POOL_SLOTS));
	assign pass_end = rd_v_s1 && (rd_idx_s1 == AW'(POOL_SLOTS - 1));
	assign last_tile = (off_x_q == OW'(SPAN - 1)) && (off_z_q == OW'(SPAN - 1));

	assign tile_x = cx_q + COORD_W'(off_x_q) - COORD_W'(RADIUS);
	assign tile_z = cz_q + COORD_W'(off_z_q) - COORD_W'(RADIUS);

	assign do_evict = (state_q == ST_EVICT) && rd_v_s1 && valid_q[rd_idx_s1]
		&& (win_outside(rd_x, cx_q, RADIUS) || win_outside(rd_z, cz_q, RADIUS));
	assign do_load = (state_q == ST_LOAD) && !match_q && free_v_q;

	assign busy      = (state_q != ST_IDLE);
	assign ram_re    = issue;
	assign ram_raddr = cnt_q[AW-1:0];
	assign ram_we    = do_load;
	assign ram_waddr = free_idx_q;
	assign ram_wdata = {tile_x, tile_z};

	always_comb begin
		ev = '0;
		ev.flush = (state_q == ST_FLUSH);
		if (do_evict) begin
			ev.new_v          = 1'b1;
			ev.res.action     = ACT_EVICT;
			ev.res.slot_index = SLOT_W'(rd_idx_s1);
			ev.res.tile_x     = rd_x;
			ev.res.tile_z     = rd_z;
		end else if (do_load) begin
			ev.new_v          = 1'b1;
			ev.res.action     = ACT_LOAD;
			ev.res.slot_index = SLOT_W'(free_idx_q);
			ev.res.tile_x     = tile_x;
			ev.res.tile_z     = tile_z;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && move) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				if (pass_end) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (pass_end) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = last_tile ? ST_FLUSH : ST_SEARCH;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			rd_v_s1      <= 1'b0;
			valid_q      <= '0;
			prev_x_q     <= '0;
			prev_z_q     <= '0;
			has_center_q <= 1'b0;
			off_x_q      <= '0;
			off_z_q      <= '0;
			match_q      <= 1'b0;
			free_v_q     <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + SW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start && move) begin
						prev_x_q     <= request.center_x;
						prev_z_q     <= request.center_z;
						has_center_q <= 1'b1;
						cnt_q        <= '0;
					end
				end
				ST_EVICT: begin
					if (do_evict) begin
						valid_q[rd_idx_s1] <= 1'b0;
					end
					if (pass_end) begin
						cnt_q    <= '0;
						match_q  <= 1'b0;
						free_v_q <= 1'b0;
						off_x_q  <= '0;
						off_z_q  <= '0;
					end
				end
				ST_SEARCH: begin
					if (rd_v_s1) begin
						if (valid_q[rd_idx_s1] && (rd_x == tile_x) && (rd_z == tile_z)) begin
							match_q <= 1'b1;
						end
						if (!valid_q[rd_idx_s1] && !free_v_q) begin
							free_v_q <= 1'b1;
						end
					end
				end
				ST_LOAD: begin
					if (do_load) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					cnt_q    <= '0;
					match_q  <= 1'b0;
					free_v_q <= 1'b0;
					if (!last_tile) begin
						if (off_z_q == OW'(SPAN - 1)) begin
							off_z_q <= '0;
							off_x_q <= off_x_q + OW'(1);
						end else begin
							off_z_q <= off_z_q + OW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[AW-1:0];
		if ((state_q == ST_IDLE) && start && move) begin
			cx_q <= request.center_x;
			cz_q <= request.center_z;
		end
		// lowest free slot of the current search
		if ((state_q == ST_SEARCH) && rd_v_s1 && !valid_q[rd_idx_s1] && !free_v_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/window_residency_slot_table.sv =====
// Channel   Ports                   Handshake
// -------   ---------------------   ------------------------------------
// request   start, busy, request    taken at edge with start & !busy
// result    result_valid, result    one-cycle strobe, no back-pressure
//
// A move makes one read pass over the slot RAM for eviction, then, for each of the
// (2R+1)^2 window tiles with R = RADIUS, one read pass plus a write step; the
// single RAM read port sets the pace.
// An unchanged center is absorbed in its accept cycle and busy never rises.
// Reset clears the valid bits and the center; the slot RAM needs no clearing.
// Results trail their discovery by one entry so the final one carries last_action.
`default_nettype none

module window_residency_slot_table #(
	parameter int POOL_SLOTS = wrst_pkg::POOL_SLOTS_DEF,
	parameter int RADIUS     = wrst_pkg::RADIUS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire wrst_pkg::req_t request,
	output logic                result_valid,
	output wrst_pkg::res_t      result
);

	import wrst_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = $clog2(POOL_SLOTS);
	localparam int DW = 2 * COORD_W;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [DW-1:0] ram_rdata;
	ev_t           ev;

	logic pend_v_q;
	res_t pend_q;
	logic result_valid_q;
	res_t result_q;

	wrst_ram #(
		.WIDTH (DW),
		.DEPTH (POOL_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	wrst_seq #(
		.POOL_SLOTS (POOL_SLOTS),
		.RADIUS     (RADIUS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.ev        (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= pend_v_q && (ev.new_v || ev.flush);
			if (ev.new_v) begin
				pend_v_q <= 1'b1;
			end else if (ev.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// held entry always has last_action clear; only the flush sets it
	always_ff @(posedge clk) begin
		if (ev.new_v) begin
			pend_q   <= ev.res;
			result_q <= pend_q;
		end else if (ev.flush) begin
			result_q <= '{action:      pend_q.action,
				slot_index:  pend_q.slot_index,
				tile_x:      pend_q.tile_x,
				tile_z:      pend_q.tile_z,
				last_action: 1'b1};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_CLK(a_more_while_busy, clk, arst_n, (result_valid && !result.last_action) |-> busy)
	`ASSERT_CLK(a_last_ends_burst, clk, arst_n, (result_valid && result.last_action) |=> !result_valid)
	`ASSERT_NEVER(a_flush_clean, clk, arst_n, ev.flush && ev.new_v)
	`ASSERT_CLK(a_load_has_free, clk, arst_n, ram_we |-> !ram_re)

endmodule

`default_nettype wire
